[hw/rtl/tklsk_pkg.sv]
// ----------------------------------------------------------------------------
// tklsk_pkg
// shared constants and controller/datapath interface types for the keeper
// ----------------------------------------------------------------------------
package tklsk_pkg;

  localparam int HEAP_DEPTH = 64;
  localparam int ADDR_W     = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int SCORE_W    = 16;
  localparam int ID_W       = 32;
  localparam int CAP_W      = 7;
  localparam int ENT_W      = SCORE_W + ID_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(HEAP_DEPTH);

  typedef struct packed {
    logic load;   // capture request and decide admission
    logic rd;     // read the neighbors of the hole
    logic step;   // compare; move one entry and advance the hole, or settle the item
  } tklsk_cmd_t;

  typedef struct packed {
    logic admit;  // offered request enters the kept set
    logic stop;   // hole has reached its final place
  } tklsk_sts_t;

endpackage

[hw/rtl/tklsk_ctrl.sv]
// ----------------------------------------------------------------------------
// tklsk_ctrl
// sequencer for load, per-level read/compare and result strobe
// ----------------------------------------------------------------------------
module tklsk_ctrl
  import tklsk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  output logic       out_strobe,
  output tklsk_cmd_t cmd,
  input  tklsk_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.admit ? S_READ : S_DONE;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = sts.stop ? S_DONE : S_READ;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = (state_r == S_DONE);

endmodule

[hw/rtl/tklsk_dp.sv]
// ----------------------------------------------------------------------------
// tklsk_dp
// heap store, moving-hole sift logic, fill count, root and capacity registers
// ----------------------------------------------------------------------------
module tklsk_dp
  import tklsk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [ID_W-1:0]    in_candidate_id,
  input  tklsk_cmd_t         cmd,
  output tklsk_sts_t         sts,
  output logic               out_accepted,
  output logic [SCORE_W-1:0] out_worst_kept_score,
  output logic [CAP_W-1:0]   out_kept_count
);

  logic [ENT_W-1:0] mem [HEAP_DEPTH];
  logic [ENT_W-1:0] rd_a_r, rd_b_r;

  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   fill_r;
  logic [SCORE_W-1:0] root_r;
  logic [SCORE_W-1:0] item_score_r;
  logic [ID_W-1:0]    item_id_r;
  logic [ADDR_W-1:0]  pos_r;
  logic               up_r;
  logic               acc_r;

  logic [CNT_W-1:0]   eff_cap;
  logic               has_room;
  logic [CNT_W:0]     left_w, right_w;
  logic [ADDR_W-1:0]  parent;
  logic [ADDR_W-1:0]  rd_a_addr, rd_b_addr;
  logic [SCORE_W-1:0] a_score, b_score, cur_score;
  logic               l_ok, r_ok, big_l, big_r;
  logic               stop_w;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr, pos_nxt;
  logic [ENT_W-1:0]   wr_data;

  // capacity clamp to 1..depth
  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (cap_r > CAP_W'(HEAP_DEPTH)) begin
      eff_cap = CNT_W'(HEAP_DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign has_room = (fill_r < eff_cap);

  assign left_w  = {pos_r, 1'b1} + (CNT_W + 1)'(0);
  assign right_w = left_w + (CNT_W + 1)'(1);
  assign parent  = ADDR_W'((pos_r - ADDR_W'(1)) >> 1);

  assign rd_a_addr = up_r ? parent : left_w[ADDR_W-1:0];
  assign rd_b_addr = right_w[ADDR_W-1:0];

  assign a_score = rd_a_r[ENT_W-1 -: SCORE_W];
  assign b_score = rd_b_r[ENT_W-1 -: SCORE_W];

  assign l_ok      = (left_w  < (CNT_W + 1)'(fill_r));
  assign r_ok      = (right_w < (CNT_W + 1)'(fill_r));
  assign big_l     = l_ok && (a_score > item_score_r);
  assign cur_score = big_l ? a_score : item_score_r;
  assign big_r     = r_ok && (b_score > cur_score);

  always_comb begin
    if (up_r) begin
      stop_w = (pos_r == '0) || (a_score >= item_score_r);
    end else begin
      stop_w = !(big_l || big_r);
    end
  end

  assign sts.admit = has_room || (in_score < root_r);
  assign sts.stop  = stop_w;

  // hole moves: write displaced entry into hole, or the item when settled
  always_comb begin
    wr_en   = cmd.step;
    wr_addr = pos_r;
    pos_nxt = pos_r;
    wr_data = {item_score_r, item_id_r};
    if (!stop_w) begin
      if (up_r) begin
        wr_data = rd_a_r;
        pos_nxt = parent;
      end else if (big_r) begin
        wr_data = rd_b_r;
        pos_nxt = right_w[ADDR_W-1:0];
      end else begin
        wr_data = rd_a_r;
        pos_nxt = left_w[ADDR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_a_r <= mem[rd_a_addr];
      rd_b_r <= mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r  <= CAP_RESET;
      fill_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.load && has_room) begin
        fill_r <= fill_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_score_r <= in_score;
      item_id_r    <= in_candidate_id;
      up_r         <= has_room;
      pos_r        <= has_room ? fill_r[ADDR_W-1:0] : '0;
      acc_r        <= sts.admit;
    end else if (cmd.step) begin
      pos_r <= pos_nxt;
    end
    if (wr_en && (wr_addr == '0)) begin
      root_r <= wr_data[ENT_W-1 -: SCORE_W];
    end
  end

  assign out_accepted         = acc_r;
  assign out_worst_kept_score = root_r;
  assign out_kept_count       = CAP_W'(fill_r);

endmodule

[hw/rtl/top_k_lowest_score_keeper_unit.sv]
// ----------------------------------------------------------------------------
// top_k_lowest_score_keeper_unit
// keeps the lowest-score candidates in a bounded max-heap, root = worst kept
// ----------------------------------------------------------------------------
//  channel   ports                                             handshake
//  request   in_score, in_candidate_id                         start & !busy
//  result    out_accepted, out_worst_kept_score, out_kept_count out_strobe
//  config    cfg_wdata (capacity)                              cfg_we
//
//  a rejected request goes from the accepting cycle straight to the
//  strobe cycle right after it
//  an admitted request runs compare steps, one more than the levels the
//  hole moves (1..7 for a 64-entry heap); each step is one registered
//  read of the heap store followed by a compare/write, and the strobe
//  comes after the last step
//  reset clears the fill count and sets capacity to the store depth; heap
//  contents are not cleared, only entries below the fill count are used
//  results cannot be stalled; busy stays high through the strobe cycle
// ----------------------------------------------------------------------------
module top_k_lowest_score_keeper_unit
  import tklsk_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_we,
  input  logic [CAP_W-1:0]   cfg_wdata,
  // request
  input  logic               start,
  output logic               busy,
  input  logic [SCORE_W-1:0] in_score,
  input  logic [ID_W-1:0]    in_candidate_id,
  // result
  output logic               out_strobe,
  output logic               out_accepted,
  output logic [SCORE_W-1:0] out_worst_kept_score,
  output logic [CAP_W-1:0]   out_kept_count
);

  tklsk_cmd_t cmd;
  tklsk_sts_t sts;

  // sequencer: idle -> (read -> compare)* -> strobe
  tklsk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd),
    .sts        (sts)
  );

  // heap store with moving hole; sift-up on insert, sift-down on root replace
  tklsk_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .in_score             (in_score),
    .in_candidate_id      (in_candidate_id),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_accepted         (out_accepted),
    .out_worst_kept_score (out_worst_kept_score),
    .out_kept_count       (out_kept_count)
  );

endmodule
